// File: sv/ptnp_pkg.sv
// ----------------------------------------------------------------------------
// ptnp_pkg: shared types and microprogram for the prime test block
// Step addresses, datapath operations, jump conditions and the control ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package ptnp_pkg;

   localparam int unsigned IN_DATA_W  = 32;
   localparam int unsigned OUT_DATA_W = 40;
   localparam int unsigned NEXT_W     = 32;

   // program addresses
   typedef enum logic [2:0] {
      S_IDLE  = 3'd0,
      S_TEST  = 3'd1,
      S_LOOP  = 3'd2,
      S_DSTEP = 3'd3,
      S_DCHK  = 3'd4,
      S_DONE  = 3'd5,
      S_NEXT  = 3'd6,
      S_OUT   = 3'd7
   } step_type;

   // datapath operations
   typedef enum logic [2:0] {
      OP_LOAD  = 3'd0,
      OP_TINIT = 3'd1,
      OP_DINIT = 3'd2,
      OP_DSTEP = 3'd3,
      OP_DNEXT = 3'd4,
      OP_SAVE  = 3'd5,
      OP_CINC  = 3'd6,
      OP_EMIT  = 3'd7
   } op_type;

   // jump conditions
   typedef enum logic [2:0] {
      COND_REQ      = 3'd0,
      COND_SMALL    = 3'd1,
      COND_SQ_GT    = 3'd2,
      COND_CNT_NZ   = 3'd3,
      COND_REM_Z    = 3'd4,
      COND_FOUND    = 3'd5,
      COND_AT_TOP   = 3'd6,
      COND_OUT_FREE = 3'd7
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type tgt_t;
      step_type tgt_f;
   } ucode_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic req;       // input word offered
      logic quick;     // n below four or even: answer known at once
      logic sq_gt;     // divisor squared exceeds n
      logic cnt_nz;    // division bits still to go
      logic rem_z;     // divisor divides n
      logic found;     // searching and candidate is prime
      logic at_top;    // candidate is the largest value of the range
      logic out_free;  // result register can take a word
   } flags_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type cw;
      unique case (step)
         S_IDLE:  cw = '{OP_LOAD,  COND_REQ,      S_TEST,  S_IDLE};
         S_TEST:  cw = '{OP_TINIT, COND_SMALL,    S_DONE,  S_LOOP};
         S_LOOP:  cw = '{OP_DINIT, COND_SQ_GT,    S_DONE,  S_DSTEP};
         S_DSTEP: cw = '{OP_DSTEP, COND_CNT_NZ,   S_DSTEP, S_DCHK};
         S_DCHK:  cw = '{OP_DNEXT, COND_REM_Z,    S_DONE,  S_LOOP};
         S_DONE:  cw = '{OP_SAVE,  COND_FOUND,    S_OUT,   S_NEXT};
         S_NEXT:  cw = '{OP_CINC,  COND_AT_TOP,   S_OUT,   S_TEST};
         S_OUT:   cw = '{OP_EMIT,  COND_OUT_FREE, S_IDLE,  S_OUT};
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

// File: sv/prime_test_next_prime.sv
// ----------------------------------------------------------------------------
// prime_test_next_prime: trial-division prime test and next-prime search
// Microcoded sequencer driving a shift-subtract remainder datapath.
// ----------------------------------------------------------------------------
// Use:
//  - req_ channel: one word carries the value to test (low VALUE_WIDTH bits
//    used). It is taken only while the sequencer sits in its idle step.
//  - rsp_ channel: one word per request: is_prime, next_prime, no_next.
//    next_prime is the smallest prime above the value within VALUE_WIDTH
//    bits; zero with no_next set when none fits.
//  - Timing: each trial divisor costs a bound check, a remainder built
//    one bit per cycle and a divisor step. A prime n tries every odd
//    divisor from three up to its square root, fewer when a small factor
//    is found; small or even numbers skip the divisor loop. An item costs
//    a load step, the test of the value, a step plus the test for every
//    candidate up to the next prime, and an output step. The serial
//    remainder unit sets the running time.
//  - Throughput: one item at a time; the next word is accepted as soon as
//    the result sits in the output register, even if it is not yet taken.
//  - Reset (synchronous) returns the sequencer to idle and empties the
//    output register. A stalled receiver holds rsp_tdata steady; the
//    sequencer waits in its output step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_test_next_prime #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [ptnp_pkg::IN_DATA_W-1:0]      req_tdata,  // [31:0] value
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] is_prime, [32:1] next_prime, [33] no_next, [39:34] zero
   output logic [ptnp_pkg::OUT_DATA_W-1:0]          rsp_tdata
);

   localparam int unsigned W     = VALUE_WIDTH;
   localparam int unsigned CNT_W = $clog2(W);
   localparam logic [W-1:0] VAL_MAX = '1;

   ptnp_pkg::op_type    op;
   ptnp_pkg::flags_type flags;

   // datapath registers
   logic [W-1:0]     cand_ff, cand_in;     // current search candidate
   logic [W-1:0]     n_ff, n_in;           // number under test
   logic [W-1:0]     d_ff, d_in;           // trial divisor (odd)
   logic [W+1:0]     sq_ff, sq_in;         // d squared, kept by increments
   logic [W-1:0]     rem_ff, rem_in;       // partial remainder
   logic [W-1:0]     sh_ff, sh_in;         // dividend bits, msb first
   logic [CNT_W-1:0] cnt_ff, cnt_in;       // remainder bit counter
   logic             res_ff, res_in;       // verdict for n so far
   logic             phase_ff, phase_in;   // low: testing value, high: searching
   logic             isp_ff, isp_in;       // verdict for the value itself
   logic [W-1:0]     found_ff, found_in;   // prime found, zero if none

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_isp_ff, rsp_isp_in;
   logic [ptnp_pkg::NEXT_W-1:0] rsp_next_ff, rsp_next_in;
   logic                      rsp_none_ff, rsp_none_in;

   logic [63:0]  req_ext;
   logic [63:0]  found_ext;
   logic [W-1:0] in_val;
   logic [W:0]   rem_sh;
   logic [W:0]   rem_diff;
   logic [W-1:0] cand_inc;
   logic         out_free;
   logic         emit;

   assign req_ext   = {32'd0, req_tdata};
   assign in_val    = req_ext[W-1:0];
   assign found_ext = 64'(found_ff);
   assign rem_sh    = {rem_ff, sh_ff[W-1]};
   assign rem_diff  = rem_sh - {1'b0, d_ff};
   assign cand_inc  = cand_ff + W'(1);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit      = (op == ptnp_pkg::OP_EMIT) && out_free;

   assign req_tready = (op == ptnp_pkg::OP_LOAD);

   always_comb begin
      flags.req      = req_tvalid;
      flags.quick    = (n_ff < W'(4)) || !n_ff[0];
      flags.sq_gt    = sq_ff > {2'b00, n_ff};
      flags.cnt_nz   = (cnt_ff != '0);
      flags.rem_z    = (rem_ff == '0);
      flags.found    = phase_ff && res_ff;
      flags.at_top   = (cand_ff == VAL_MAX);
      flags.out_free = out_free;
   end

   ptnp_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .op    (op)
   );

   always_comb begin
      cand_in  = cand_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      sh_in    = sh_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      phase_in = phase_ff;
      isp_in   = isp_ff;
      found_in = found_ff;
      unique case (op)
         ptnp_pkg::OP_LOAD: begin
            if (req_tvalid) begin
               cand_in  = in_val;
               n_in     = in_val;
               phase_in = 1'b0;
               found_in = '0;
            end
         end
         ptnp_pkg::OP_TINIT: begin
            // below four: prime iff two or three; otherwise odd survives for now
            res_in = (n_ff < W'(4)) ? (n_ff >= W'(2)) : n_ff[0];
            d_in   = W'(3);
            sq_in  = (W+2)'(9);
         end
         ptnp_pkg::OP_DINIT: begin
            rem_in = '0;
            sh_in  = n_ff;
            cnt_in = CNT_W'(W-1);
         end
         ptnp_pkg::OP_DSTEP: begin
            rem_in = rem_diff[W] ? rem_sh[W-1:0] : rem_diff[W-1:0];
            sh_in  = {sh_ff[W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         ptnp_pkg::OP_DNEXT: begin
            // (d+2)^2 = d^2 + 4d + 4
            res_in = res_ff && (rem_ff != '0);
            d_in   = d_ff + W'(2);
            sq_in  = sq_ff + {d_ff, 2'b00} + (W+2)'(4);
         end
         ptnp_pkg::OP_SAVE: begin
            if (!phase_ff) begin
               isp_in   = res_ff;
               phase_in = 1'b1;
            end else if (res_ff) begin
               found_in = cand_ff;
            end
         end
         ptnp_pkg::OP_CINC: begin
            if (cand_ff != VAL_MAX) begin
               cand_in = cand_inc;
               n_in    = cand_inc;
            end
         end
         ptnp_pkg::OP_EMIT: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_isp_in   = rsp_isp_ff;
      rsp_next_in  = rsp_next_ff;
      rsp_none_in  = rsp_none_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_isp_in   = isp_ff;
         rsp_next_in  = found_ext[ptnp_pkg::NEXT_W-1:0];
         rsp_none_in  = (found_ff == '0);  // a prime is never zero
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      n_ff        <= n_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      rem_ff      <= rem_in;
      sh_ff       <= sh_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      phase_ff    <= phase_in;
      isp_ff      <= isp_in;
      found_ff    <= found_in;
      rsp_isp_ff  <= rsp_isp_in;
      rsp_next_ff <= rsp_next_in;
      rsp_none_ff <= rsp_none_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_none_ff, rsp_next_ff, rsp_isp_ff};

endmodule

`default_nettype wire

// File: sv/ptnp_seq.sv
// ----------------------------------------------------------------------------
// ptnp_seq: microprogram sequencer
// Step counter over the control ROM; selects the jump condition each step.
// ----------------------------------------------------------------------------
`default_nettype none

module ptnp_seq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ptnp_pkg::flags_type flags,
   output ptnp_pkg::op_type         op
);

   ptnp_pkg::step_type  step_ff;
   ptnp_pkg::step_type  step_in;
   ptnp_pkg::ucode_type cw;
   logic                take;

   always_comb begin
      cw = ptnp_pkg::ucode_rom(step_ff);
      unique case (cw.cond)
         ptnp_pkg::COND_REQ:      take = flags.req;
         ptnp_pkg::COND_SMALL:    take = flags.quick;
         ptnp_pkg::COND_SQ_GT:    take = flags.sq_gt;
         ptnp_pkg::COND_CNT_NZ:   take = flags.cnt_nz;
         ptnp_pkg::COND_REM_Z:    take = flags.rem_z;
         ptnp_pkg::COND_FOUND:    take = flags.found;
         ptnp_pkg::COND_AT_TOP:   take = flags.at_top;
         ptnp_pkg::COND_OUT_FREE: take = flags.out_free;
      endcase
      step_in = take ? cw.tgt_t : cw.tgt_f;
   end

   assign op = cw.op;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ptnp_pkg::S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire
